// ===== design/lia_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, command codes and controller/datapath interface types.
package lia_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int REF_BITS    = 16;
	localparam int FRAC_BITS   = 16;
	localparam int ACC_BITS    = 64;
	localparam int RES_BITS    = 48;
	localparam int CFG_BITS    = 20;
	localparam int RESIST_BITS = 20;
	localparam int SPW_BITS    = 13;
	localparam int WC_BITS     = 16;
	localparam int CNT_BITS    = SPW_BITS + WC_BITS;
	localparam int IDX_BITS    = 2;
	localparam int DIFF_BITS   = ACC_BITS + 1;
	localparam int MY_BITS     = DIFF_BITS + 1;
	localparam int PW          = 152;
	localparam int DEN_BITS    = 130;
	localparam int NW          = 168;
	localparam int QW          = RES_BITS + 1;
	localparam int DCNT_BITS   = 8;
	localparam int STEP_BITS   = 4;

	localparam logic [IDX_BITS-1:0] CFG_RESIST = 2'd0;
	localparam logic [IDX_BITS-1:0] CFG_SPW    = 2'd1;
	localparam logic [IDX_BITS-1:0] CFG_WC     = 2'd2;

	localparam logic DS_RE = 1'b0;
	localparam logic DS_IM = 1'b1;

	typedef enum logic [2:0] {
		OP_NONE, OP_DIFF, OP_MUL, OP_STORE_DEN, OP_STORE_RE, OP_STORE_IM, OP_DIV, OP_LOAD_OUT
	} dp_op_t;

	typedef enum logic [2:0] {
		MS_CC, MS_DD, MS_AC, MS_BD, MS_BC, MS_AD, MS_PR
	} msel_t;

	typedef struct packed {
		logic   accept;
		dp_op_t op;
		msel_t  msel;
		logic   mclr;
		logic   mneg;
		logic   dsel;
	} dp_cmd_t;

	typedef struct packed {
		logic last;
		logic busy;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== design/lockin_impedance_accumulator.sv =====
`timescale 1ns / 1ps
// Top level of the quadrature lock-in impedance accumulator.
//
// Usage: the input channel (in_valid/in_ready) carries one sample pair with its
// sine and cosine reference per transfer. Each accepted pair is multiplied by both
// references and folded into four 64-bit running sums as it is taken, so while a
// measurement is being gathered the block takes one pair per cycle.
// When wave_count * samples_per_wave pairs have been taken (or one pair, if that
// product is zero), the sums are captured and cleared and the impedance
// R * I / (T - I) is worked out by a sequencer driving a shared shift-add
// multiplier (one multiplier bit per cycle, eight products) and a restoring
// divider (one quotient bit per cycle, one division per component). While that
// runs, in_ready is low.
// The result then sits in the output register (out_valid/out_ready) and a new
// measurement can be gathered while it waits; only the next completed measurement
// holds until the receiver has taken the previous transfer.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once and
// leave the sums alone. Asynchronous reset restores the register defaults, clears
// the sums and counter, drops out_valid and leaves in_ready high.
module lockin_impedance_accumulator (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_write,
	input  logic [lia_pkg::IDX_BITS-1:0]            cfg_index,
	input  logic [lia_pkg::CFG_BITS-1:0]            cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [lia_pkg::SAMPLE_BITS-1:0]  total_sample,
	input  logic signed [lia_pkg::SAMPLE_BITS-1:0]  inductor_sample,
	input  logic signed [lia_pkg::REF_BITS-1:0]     sine_ref,
	input  logic signed [lia_pkg::REF_BITS-1:0]     cosine_ref,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [lia_pkg::ACC_BITS-1:0]     inductor_in_phase,
	output logic signed [lia_pkg::ACC_BITS-1:0]     inductor_quadrature,
	output logic signed [lia_pkg::ACC_BITS-1:0]     total_in_phase,
	output logic signed [lia_pkg::ACC_BITS-1:0]     total_quadrature,
	output logic signed [lia_pkg::RES_BITS-1:0]     impedance_real,
	output logic signed [lia_pkg::RES_BITS-1:0]     impedance_imag,
	output logic                                    divide_error
);
	import lia_pkg::*;

	// Commands flow from the sequencer to the datapath; status flows back.
	dp_cmd_t  cmd;
	dp_stat_t stat;

	lia_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lia_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_write           (cfg_write),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.total_sample        (total_sample),
		.inductor_sample     (inductor_sample),
		.sine_ref            (sine_ref),
		.cosine_ref          (cosine_ref),
		.cmd                 (cmd),
		.stat                (stat),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.inductor_in_phase   (inductor_in_phase),
		.inductor_quadrature (inductor_quadrature),
		.total_in_phase      (total_in_phase),
		.total_quadrature    (total_quadrature),
		.impedance_real      (impedance_real),
		.impedance_imag      (impedance_imag),
		.divide_error        (divide_error)
	);

endmodule

// ===== design/lia_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer that steps the datapath through the impedance computation.
module lia_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lia_pkg::dp_stat_t stat,
	output lia_pkg::dp_cmd_t  cmd
);
	import lia_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_OUT} state_t;

	localparam logic [STEP_BITS-1:0] LAST_STEP = 4'd13;

	state_t               state_q;
	logic [STEP_BITS-1:0] step_q;

	// Micro-sequence: each step is one datapath operation.
	function automatic dp_cmd_t step_cmd(input logic [STEP_BITS-1:0] s);
		dp_cmd_t c;
		c = '{accept: 1'b0, op: OP_NONE, msel: MS_CC, mclr: 1'b0, mneg: 1'b0, dsel: DS_RE};
		case (s)
			4'd0: c.op = OP_DIFF;
			4'd1: begin c.op = OP_MUL; c.msel = MS_CC; c.mclr = 1'b1; end
			4'd2: begin c.op = OP_MUL; c.msel = MS_DD; end
			4'd3: c.op = OP_STORE_DEN;
			4'd4: begin c.op = OP_MUL; c.msel = MS_AC; c.mclr = 1'b1; end
			4'd5: begin c.op = OP_MUL; c.msel = MS_BD; end
			4'd6: begin c.op = OP_MUL; c.msel = MS_PR; c.mclr = 1'b1; end
			4'd7: c.op = OP_STORE_RE;
			4'd8: begin c.op = OP_MUL; c.msel = MS_BC; c.mclr = 1'b1; end
			4'd9: begin c.op = OP_MUL; c.msel = MS_AD; c.mneg = 1'b1; end
			4'd10: begin c.op = OP_MUL; c.msel = MS_PR; c.mclr = 1'b1; end
			4'd11: c.op = OP_STORE_IM;
			4'd12: begin c.op = OP_DIV; c.dsel = DS_RE; end
			4'd13: begin c.op = OP_DIV; c.dsel = DS_IM; end
			default: c.op = OP_NONE;
		endcase
		return c;
	endfunction

	always_comb begin
		in_ready = (state_q == S_IDLE);
		cmd = '{accept: 1'b0, op: OP_NONE, msel: MS_CC, mclr: 1'b0, mneg: 1'b0, dsel: DS_RE};
		case (state_q)
			S_IDLE:  cmd.accept = in_valid;
			S_ISSUE: cmd = step_cmd(step_q);
			S_OUT:   if (stat.out_free) cmd.op = OP_LOAD_OUT;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid && stat.last) begin
						state_q <= S_ISSUE;
						step_q  <= '0;
					end
				end
				S_ISSUE: state_q <= S_WAIT;
				S_WAIT: begin
					if (!stat.busy) begin
						if (step_q == LAST_STEP) begin
							state_q <= S_OUT;
						end else begin
							step_q  <= step_q + 4'd1;
							state_q <= S_ISSUE;
						end
					end
				end
				S_OUT: if (stat.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== design/lia_dp.sv =====
`timescale 1ns / 1ps
// Accumulators, shift-add multiplier, restoring divider and result registers.
module lia_dp (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_write,
	input  logic [lia_pkg::IDX_BITS-1:0]            cfg_index,
	input  logic [lia_pkg::CFG_BITS-1:0]            cfg_data,
	input  logic signed [lia_pkg::SAMPLE_BITS-1:0]  total_sample,
	input  logic signed [lia_pkg::SAMPLE_BITS-1:0]  inductor_sample,
	input  logic signed [lia_pkg::REF_BITS-1:0]     sine_ref,
	input  logic signed [lia_pkg::REF_BITS-1:0]     cosine_ref,
	input  lia_pkg::dp_cmd_t                        cmd,
	output lia_pkg::dp_stat_t                       stat,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [lia_pkg::ACC_BITS-1:0]     inductor_in_phase,
	output logic signed [lia_pkg::ACC_BITS-1:0]     inductor_quadrature,
	output logic signed [lia_pkg::ACC_BITS-1:0]     total_in_phase,
	output logic signed [lia_pkg::ACC_BITS-1:0]     total_quadrature,
	output logic signed [lia_pkg::RES_BITS-1:0]     impedance_real,
	output logic signed [lia_pkg::RES_BITS-1:0]     impedance_imag,
	output logic                                    divide_error
);
	import lia_pkg::*;

	localparam int PROD_BITS = SAMPLE_BITS + REF_BITS;
	localparam logic [QW-1:0] LIM = {2'b00, {(QW-2){1'b1}}};
	localparam logic [QW-1:0] LIM1 = {2'b01, {(QW-2){1'b0}}};

	// Configuration
	logic [RESIST_BITS-1:0] resist_q;
	logic [SPW_BITS-1:0]    spw_q;
	logic [WC_BITS-1:0]     wc_q;

	// Running sums and snapshot
	logic signed [ACC_BITS-1:0] ind_ip_q, ind_q_q, tot_ip_q, tot_q_q;
	logic signed [ACC_BITS-1:0] a_q, b_q, tip_q, tq_q;
	logic [CNT_BITS-1:0]        pair_q;

	logic signed [DIFF_BITS-1:0] c_q, d_q;
	logic [DEN_BITS-1:0]         den_q;
	logic signed [PW-1:0]        nre_q, nim_q;

	// Multiplier
	logic signed [PW-1:0] p_q, xs_q;
	logic [MY_BITS-1:0]   ym_q;
	logic                 mneg_q, mbusy_q;

	// Divider
	logic [NW-1:0]        num_q, rem_q, dvs_q;
	logic [QW-1:0]        quo_q;
	logic                 big_q, dneg_q, dsel_q, dbusy_q;
	logic [DCNT_BITS-1:0] dcnt_q;
	logic [RES_BITS-1:0]  zre_q, zim_q;

	logic out_valid_q;

	// Combinational helpers
	logic [CNT_BITS-1:0]         target;
	logic [CNT_BITS:0]           cnt_next;
	logic signed [PROD_BITS-1:0] p_ic, p_is, p_tc, p_ts;
	logic signed [ACC_BITS-1:0]  n_ind_ip, n_ind_q, n_tot_ip, n_tot_q;
	logic signed [PW-1:0]        mx;
	logic signed [MY_BITS-1:0]   my;
	logic signed [PW-1:0]        dsrc;
	logic [PW-1:0]               dmag;
	logic [NW-1:0]               rem_sh;
	logic                        ge;
	logic [RES_BITS-1:0]         zsat;

	assign target   = CNT_BITS'(wc_q) * CNT_BITS'(spw_q);
	assign cnt_next = {1'b0, pair_q} + {{CNT_BITS{1'b0}}, 1'b1};
	assign stat.last = (target == '0) || (cnt_next >= {1'b0, target});
	assign stat.busy = mbusy_q | dbusy_q;
	assign stat.out_free = !out_valid_q || out_ready;

	assign p_ic = inductor_sample * cosine_ref;
	assign p_is = inductor_sample * sine_ref;
	assign p_tc = total_sample * cosine_ref;
	assign p_ts = total_sample * sine_ref;
	assign n_ind_ip = ind_ip_q + ACC_BITS'(p_ic);
	assign n_ind_q  = ind_q_q  - ACC_BITS'(p_is);
	assign n_tot_ip = tot_ip_q + ACC_BITS'(p_tc);
	assign n_tot_q  = tot_q_q  - ACC_BITS'(p_ts);

	always_comb begin
		case (cmd.msel)
			MS_CC: begin mx = PW'(c_q); my = MY_BITS'(c_q); end
			MS_DD: begin mx = PW'(d_q); my = MY_BITS'(d_q); end
			MS_AC: begin mx = PW'(a_q); my = MY_BITS'(c_q); end
			MS_BD: begin mx = PW'(b_q); my = MY_BITS'(d_q); end
			MS_BC: begin mx = PW'(b_q); my = MY_BITS'(c_q); end
			MS_AD: begin mx = PW'(a_q); my = MY_BITS'(d_q); end
			MS_PR: begin mx = p_q; my = signed'({{(MY_BITS-RESIST_BITS){1'b0}}, resist_q}); end
			default: begin mx = '0; my = '0; end
		endcase
	end

	assign dsrc = (cmd.dsel == DS_IM) ? nim_q : nre_q;
	assign dmag = dsrc[PW-1] ? unsigned'(-dsrc) : unsigned'(dsrc);
	assign rem_sh = {rem_q[NW-2:0], num_q[NW-1]};
	assign ge = (rem_sh >= dvs_q);

	// Round-to-nearest quotient with sign and 48-bit saturation
	always_comb begin
		if (!dneg_q) begin
			zsat = (big_q || quo_q > LIM) ? LIM[RES_BITS-1:0] : quo_q[RES_BITS-1:0];
		end else if (big_q || quo_q > LIM1) begin
			zsat = LIM1[RES_BITS-1:0];
		end else begin
			zsat = RES_BITS'(-quo_q);
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resist_q    <= RESIST_BITS'(1000);
			spw_q       <= SPW_BITS'(256);
			wc_q        <= WC_BITS'(1);
			ind_ip_q    <= '0;
			ind_q_q     <= '0;
			tot_ip_q    <= '0;
			tot_q_q     <= '0;
			pair_q      <= '0;
			mbusy_q     <= 1'b0;
			dbusy_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_RESIST: resist_q <= cfg_data[RESIST_BITS-1:0];
					CFG_SPW:    spw_q    <= cfg_data[SPW_BITS-1:0];
					CFG_WC:     wc_q     <= cfg_data[WC_BITS-1:0];
					default:    ;
				endcase
			end
			if (cmd.accept) begin
				if (stat.last) begin
					ind_ip_q <= '0;
					ind_q_q  <= '0;
					tot_ip_q <= '0;
					tot_q_q  <= '0;
					pair_q   <= '0;
				end else begin
					ind_ip_q <= n_ind_ip;
					ind_q_q  <= n_ind_q;
					tot_ip_q <= n_tot_ip;
					tot_q_q  <= n_tot_q;
					pair_q   <= cnt_next[CNT_BITS-1:0];
				end
			end
			if (cmd.op == OP_MUL) mbusy_q <= 1'b1;
			else if (mbusy_q && ym_q == '0) mbusy_q <= 1'b0;
			if (cmd.op == OP_DIV) dbusy_q <= 1'b1;
			else if (dbusy_q && dcnt_q == '0) dbusy_q <= 1'b0;
			if (cmd.op == OP_LOAD_OUT) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept && stat.last) begin
			a_q   <= n_ind_ip;
			b_q   <= n_ind_q;
			tip_q <= n_tot_ip;
			tq_q  <= n_tot_q;
		end
		if (cmd.op == OP_DIFF) begin
			c_q <= DIFF_BITS'(tip_q) - DIFF_BITS'(a_q);
			d_q <= DIFF_BITS'(tq_q) - DIFF_BITS'(b_q);
		end
		if (cmd.op == OP_STORE_DEN) den_q <= p_q[DEN_BITS-1:0];
		if (cmd.op == OP_STORE_RE) nre_q <= p_q;
		if (cmd.op == OP_STORE_IM) nim_q <= p_q;

		if (cmd.op == OP_MUL) begin
			xs_q   <= mx;
			ym_q   <= my[MY_BITS-1] ? unsigned'(-my) : unsigned'(my);
			mneg_q <= my[MY_BITS-1] ^ cmd.mneg;
			if (cmd.mclr) p_q <= '0;
		end else if (mbusy_q && ym_q != '0) begin
			if (ym_q[0]) p_q <= mneg_q ? p_q - xs_q : p_q + xs_q;
			xs_q <= xs_q <<< 1;
			ym_q <= ym_q >> 1;
		end

		if (cmd.op == OP_DIV) begin
			num_q  <= (NW'(dmag) << (FRAC_BITS + 1)) + NW'(den_q);
			dvs_q  <= NW'(den_q) << 1;
			rem_q  <= '0;
			quo_q  <= '0;
			big_q  <= 1'b0;
			dneg_q <= dsrc[PW-1];
			dsel_q <= cmd.dsel;
			dcnt_q <= DCNT_BITS'(NW);
		end else if (dbusy_q) begin
			if (dcnt_q == '0) begin
				if (dsel_q == DS_IM) zim_q <= zsat;
				else zre_q <= zsat;
			end else begin
				rem_q  <= ge ? rem_sh - dvs_q : rem_sh;
				num_q  <= num_q << 1;
				quo_q  <= {quo_q[QW-2:0], ge};
				big_q  <= big_q | quo_q[QW-1];
				dcnt_q <= dcnt_q - 8'd1;
			end
		end

		if (cmd.op == OP_LOAD_OUT) begin
			inductor_in_phase   <= a_q;
			inductor_quadrature <= b_q;
			total_in_phase      <= tip_q;
			total_quadrature    <= tq_q;
			divide_error        <= (den_q == '0);
			impedance_real      <= (den_q == '0) ? '0 : signed'(zre_q);
			impedance_imag      <= (den_q == '0) ? '0 : signed'(zim_q);
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sim/lia_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the lock-in impedance accumulator: predicts each measurement and checks it.
module lia_checker (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_write,
	input  logic [lia_pkg::IDX_BITS-1:0]            cfg_index,
	input  logic [lia_pkg::CFG_BITS-1:0]            cfg_data,
	input  logic                                    in_valid,
	input  logic                                    in_ready,
	input  logic signed [lia_pkg::SAMPLE_BITS-1:0]  total_sample,
	input  logic signed [lia_pkg::SAMPLE_BITS-1:0]  inductor_sample,
	input  logic signed [lia_pkg::REF_BITS-1:0]     sine_ref,
	input  logic signed [lia_pkg::REF_BITS-1:0]     cosine_ref,
	input  logic                                    out_valid,
	input  logic                                    out_ready,
	input  logic signed [lia_pkg::ACC_BITS-1:0]     inductor_in_phase,
	input  logic signed [lia_pkg::ACC_BITS-1:0]     inductor_quadrature,
	input  logic signed [lia_pkg::ACC_BITS-1:0]     total_in_phase,
	input  logic signed [lia_pkg::ACC_BITS-1:0]     total_quadrature,
	input  logic signed [lia_pkg::RES_BITS-1:0]     impedance_real,
	input  logic signed [lia_pkg::RES_BITS-1:0]     impedance_imag,
	input  logic                                    divide_error,
	output int                                      mismatches,
	output int                                      pending
);
	import lia_pkg::*;

	typedef logic signed [255:0] wide_t;

	typedef struct {
		logic signed [ACC_BITS-1:0] ind_i, ind_q, tot_i, tot_q;
		logic signed [RES_BITS-1:0] z_re, z_im;
		logic                       div_err;
	} measurement_t;

	measurement_t measurements_due[$];

	logic [RESIST_BITS-1:0]     resistance;
	logic [SPW_BITS-1:0]        pairs_per_wave;
	logic [WC_BITS-1:0]         waves;
	logic signed [ACC_BITS-1:0] ind_i_sum, ind_q_sum, tot_i_sum, tot_q_sum;
	logic [31:0]                pairs_taken;

	assign pending = measurements_due.size();

	// Rounds num/den to nearest, ties away from zero, and clamps to the 48-bit range.
	function automatic logic [RES_BITS-1:0] rounded_quotient(wide_t num, wide_t den);
		logic [255:0] mag;
		logic [255:0] q;
		logic [255:0] lim;
		lim = (256'd1 << (RES_BITS - 1)) - 1;
		mag = num[255] ? -num : num;
		q = (2 * mag + den) / (2 * den);
		if (!num[255])
			return (q > lim) ? lim[RES_BITS-1:0] : q[RES_BITS-1:0];
		if (q > lim + 1)
			return {1'b1, {(RES_BITS-1){1'b0}}};
		return RES_BITS'(-q);
	endfunction

	function automatic measurement_t impedance_of_sums();
		measurement_t m;
		wide_t a, b, c, d, den, r, nre, nim;
		m.ind_i = ind_i_sum;
		m.ind_q = ind_q_sum;
		m.tot_i = tot_i_sum;
		m.tot_q = tot_q_sum;
		a = ind_i_sum;
		b = ind_q_sum;
		c = wide_t'(tot_i_sum) - a;
		d = wide_t'(tot_q_sum) - b;
		den = c * c + d * d;
		if (den == 0) begin
			m.z_re = '0;
			m.z_im = '0;
			m.div_err = 1'b1;
		end else begin
			r = {236'b0, resistance};
			nre = (r * (a * c + b * d)) <<< FRAC_BITS;
			nim = (r * (b * c - a * d)) <<< FRAC_BITS;
			m.z_re = rounded_quotient(nre, den);
			m.z_im = rounded_quotient(nim, den);
			m.div_err = 1'b0;
		end
		return m;
	endfunction

	task automatic compare(string field, logic [ACC_BITS-1:0] want, logic [ACC_BITS-1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [31:0]                target;
		logic [31:0]                count;
		logic signed [ACC_BITS-1:0] ind, tot, sn, cs;
		measurement_t               m;
		if (!arst_n) begin
			resistance     <= RESIST_BITS'(1000);
			pairs_per_wave <= SPW_BITS'(256);
			waves          <= WC_BITS'(1);
			ind_i_sum      <= '0;
			ind_q_sum      <= '0;
			tot_i_sum      <= '0;
			tot_q_sum      <= '0;
			pairs_taken    <= '0;
			measurements_due.delete();
			mismatches     <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_RESIST: resistance <= cfg_data[RESIST_BITS-1:0];
					CFG_SPW:    pairs_per_wave <= cfg_data[SPW_BITS-1:0];
					CFG_WC:     waves <= cfg_data[WC_BITS-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				ind = ACC_BITS'(inductor_sample);
				tot = ACC_BITS'(total_sample);
				sn  = ACC_BITS'(sine_ref);
				cs  = ACC_BITS'(cosine_ref);
				ind_i_sum = ind_i_sum + ind * cs;
				ind_q_sum = ind_q_sum - ind * sn;
				tot_i_sum = tot_i_sum + tot * cs;
				tot_q_sum = tot_q_sum - tot * sn;
				target = 32'(pairs_per_wave) * 32'(waves);
				if (target == 0)
					target = 1;
				count = pairs_taken + 32'd1;
				if (count < target) begin
					pairs_taken <= count;
				end else begin
					measurements_due.push_back(impedance_of_sums());
					ind_i_sum = '0;
					ind_q_sum = '0;
					tot_i_sum = '0;
					tot_q_sum = '0;
					pairs_taken <= '0;
				end
			end
			if (out_valid && out_ready) begin
				if (measurements_due.size() == 0) begin
					$display("%0t: result transfer with nothing expected", $time);
					mismatches++;
				end else begin
					m = measurements_due.pop_front();
					compare("inductor_in_phase", m.ind_i, inductor_in_phase);
					compare("inductor_quadrature", m.ind_q, inductor_quadrature);
					compare("total_in_phase", m.tot_i, total_in_phase);
					compare("total_quadrature", m.tot_q, total_quadrature);
					compare("impedance_real", 64'(m.z_re), 64'(impedance_real));
					compare("impedance_imag", 64'(m.z_im), 64'(impedance_imag));
					compare("divide_error", 64'(m.div_err), 64'(divide_error));
				end
			end
		end
	end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the lock-in impedance accumulator testbench.
module tb_top;
	import lia_pkg::*;

	localparam int STALL_LIMIT = 6000;
	localparam int TOTAL_ITEMS = 950;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_write;
	logic [IDX_BITS-1:0]           cfg_index;
	logic [CFG_BITS-1:0]           cfg_data;
	logic                          in_valid;
	logic                          in_ready;
	logic signed [SAMPLE_BITS-1:0] total_sample;
	logic signed [SAMPLE_BITS-1:0] inductor_sample;
	logic signed [REF_BITS-1:0]    sine_ref;
	logic signed [REF_BITS-1:0]    cosine_ref;
	logic                          out_valid;
	logic                          out_ready;
	logic signed [ACC_BITS-1:0]    inductor_in_phase;
	logic signed [ACC_BITS-1:0]    inductor_quadrature;
	logic signed [ACC_BITS-1:0]    total_in_phase;
	logic signed [ACC_BITS-1:0]    total_quadrature;
	logic signed [RES_BITS-1:0]    impedance_real;
	logic signed [RES_BITS-1:0]    impedance_imag;
	logic                          divide_error;
	int                            mismatches;
	int                            pending;

	// Once set, neither side idles any more, so the tail of the run is back-to-back.
	bit calm;
	int pairs_sent;
	int quiet_cycles;

	lockin_impedance_accumulator dut (.*);

	lia_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The watchdog counts cycles in which neither channel completes a transfer. The
	// longest legitimate gap is one impedance computation plus a receiver stall, so
	// the limit leaves a wide margin.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// The receiver switches at random between bursts of readiness and stalls, and stays ready once calm is set.
	initial begin
		int left;
		out_ready = 1'b0;
		left = 0;
		forever begin
			@(negedge clk);
			if (calm) begin
				out_ready <= 1'b1;
			end else if (left == 0) begin
				if ($urandom_range(1, 0) == 1) begin
					out_ready <= 1'b0;
					left = $urandom_range(14, 1);
				end else begin
					out_ready <= 1'b1;
					left = $urandom_range(30, 1);
				end
			end else begin
				left--;
			end
		end
	end

	// Presents one sample pair and returns at the edge where it is taken. A random
	// idle burst may come first; otherwise valid stays high from the previous pair.
	task automatic send_pair(int tot, int ind, int sn, int cs);
		int gap;
		gap = (!calm && $urandom_range(3, 0) == 0) ? $urandom_range(14, 1) : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid        <= 1'b1;
		total_sample    <= SAMPLE_BITS'(tot);
		inductor_sample <= SAMPLE_BITS'(ind);
		sine_ref        <= REF_BITS'(sn);
		cosine_ref      <= REF_BITS'(cs);
		do
			@(posedge clk);
		while (!in_ready);
		pairs_sent++;
	endtask

	// Register writes only happen once the block has no measurement outstanding.
	task automatic write_register(logic [IDX_BITS-1:0] idx, int unsigned value);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_BITS-1:0];
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_length(int unsigned spw, int unsigned wc);
		write_register(CFG_SPW, spw);
		write_register(CFG_WC, wc);
	endtask

	// Random pair: mostly full-range, sometimes with the two samples close together
	// so that the denominator is small and the quotient large.
	task automatic random_pair();
		int tot, ind;
		ind = $urandom_range(4095, 0) - 2048;
		if ($urandom_range(4, 0) == 0) begin
			tot = ind + $urandom_range(4, 0) - 2;
			if (tot > 2047) tot = 2047;
			if (tot < -2048) tot = -2048;
		end else begin
			tot = $urandom_range(4095, 0) - 2048;
		end
		send_pair(tot, ind, $urandom_range(65535, 0) - 32768,
			$urandom_range(65535, 0) - 32768);
	endtask

	initial begin
		int phase_len;
		int r;
		calm            = 1'b0;
		pairs_sent      = 0;
		quiet_cycles    = 0;
		arst_n          = 1'b0;
		cfg_write       = 1'b0;
		cfg_index       = CFG_RESIST;
		cfg_data        = '0;
		in_valid        = 1'b0;
		total_sample    = '0;
		inductor_sample = '0;
		sine_ref        = '0;
		cosine_ref      = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: two-pair measurements first.
		write_register(CFG_RESIST, 1000);
		set_length(2, 1);
		send_pair(2047, -2048, -32768, 32767);
		send_pair(-2048, 2047, 32767, -32768);
		// Equal samples throughout give a zero denominator.
		send_pair(5, 5, 100, -200);
		send_pair(0, 0, 0, 0);
		// A huge inductor phasor over a tiny difference saturates both ways.
		write_register(CFG_RESIST, 1000000);
		send_pair(2047, 2047, 0, 32767);
		send_pair(1, 0, 0, 1);
		send_pair(-2048, -2048, 32767, -32768);
		send_pair(-1, 0, 1, 0);
		// Zero resistance gives a zero impedance without an error.
		write_register(CFG_RESIST, 0);
		send_pair(100, -30, 500, 700);
		send_pair(7, 9, -3, 11);
		// A zero measurement length makes every pair a measurement of its own.
		write_register(CFG_RESIST, 1);
		set_length(0, 0);
		send_pair(-2048, 2047, -32768, -32768);
		send_pair(2047, -2048, 32767, 32767);
		// A long length, then lowered mid-measurement: the next pair completes it.
		set_length(4096, 65535);
		send_pair(300, -400, 1234, -4321);
		send_pair(-5, 17, -32768, 32767);
		send_pair(2047, 2047, 32767, 32767);
		set_length(2, 1);
		send_pair(-2048, 1000, 12345, -23456);

		// Random part: phases of different settings, each set up once no result is pending.
		// In the calm tail the settings stay put so that pairs follow without pauses.
		while (pairs_sent < TOTAL_ITEMS) begin
			if (!calm) begin
				r = $urandom_range(5, 0);
				case (r)
					0: write_register(CFG_RESIST, 1);
					1: write_register(CFG_RESIST, 1000000);
					2: write_register(CFG_RESIST, 0);
					default: write_register(CFG_RESIST, $urandom_range(1000000, 1));
				endcase
				if ($urandom_range(5, 0) == 0)
					set_length($urandom_range(40, 2), $urandom_range(2, 1));
				else
					set_length($urandom_range(6, 2), $urandom_range(2, 1));
			end
			phase_len = $urandom_range(80, 30);
			if (pairs_sent > TOTAL_ITEMS - 150)
				calm = 1'b1;
			repeat (phase_len) random_pair();
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (50) @(negedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== lockin_impedance_accumulator.f =====
design/lia_pkg.sv
design/lia_ctrl.sv
design/lia_dp.sv
design/lockin_impedance_accumulator.sv
sim/lia_checker.sv
sim/tb_top.sv
